// ----- design/sorted_priority_queue_unit_defines.svh -----
// Assertion helpers for the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle check, clocked on aclk, off while in reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check on the cycle after the trigger.
`define SPQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH     = 8;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 4;
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Broadcast to every cell; insert/remove are already qualified.
    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- design/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// A result is registered and appears on m_ in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while m_tready is high; insert and remove finish
// in a single shift of the cell chain, and s_tready stays high while the output is drained.
// Reset (aresetn low, synchronous) empties the queue and drops m_tvalid;
// entry contents are not cleared.
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] operation, [33:2] value, [39:34] zero
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [33:2] min_value, [37:34] count, [39:38] zero
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import spq_pkg::*;

    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [M_TDATA_W-1:0]     m_data_reg;
    logic [M_TDATA_W-1:0]     m_data_next;

    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] in_value;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] min_value;
    cell_cmd_t                cmd;

    logic signed [DATA_W-1:0] cell_entry [DEPTH];
    logic                     cell_ins   [DEPTH];

    assign op       = s_tdata[OP_W-1:0];
    assign in_value = s_tdata[OP_W +: DATA_W];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (occ_reg == OCC_W'(DEPTH));
    assign empty    = (occ_reg == '0);

    always_comb begin
        cmd.insert = 1'b0;
        cmd.remove = 1'b0;
        cmd.value  = in_value;
        status     = ST_OK;
        min_value  = '0;
        occ_next   = occ_reg;
        unique case (op)
            OP_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.insert = accept;
                    occ_next   = occ_reg + OCC_W'(1);
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    min_value  = cell_entry[0];
                    cmd.remove = accept;
                    occ_next   = occ_reg - OCC_W'(1);
                end
            end
            OP_PEEK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    min_value = cell_entry[0];
                end
            end
            default: begin
            end
        endcase
        if (!accept) begin
            occ_next = occ_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            localparam logic [OCC_W-1:0] IDX = OCC_W'(i);
            logic                     live;
            logic                     left_ins;
            logic signed [DATA_W-1:0] left_entry;
            logic signed [DATA_W-1:0] right_entry;

            assign live = (occ_reg > IDX);
            if (i == 0) begin : g_head
                assign left_ins   = 1'b0;
                assign left_entry = cell_entry[0];
            end else begin : g_body
                assign left_ins   = cell_ins[i-1];
                assign left_entry = cell_entry[i-1];
            end
            if (i == DEPTH - 1) begin : g_tail
                assign right_entry = cell_entry[i];
            end else begin : g_mid
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .live        (live),
                .left_ins    (left_ins),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (cell_entry[i]),
                .ins_here    (cell_ins[i])
            );
        end
    endgenerate

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {(M_TDATA_W - ST_W - DATA_W - CNT_W)'(0),
                            CNT_W'(occ_next), min_value, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Live entries must stay in ascending order.
    logic sorted_ok;
    always_comb begin
        sorted_ok = 1'b1;
        for (int k = 0; k < DEPTH - 1; k++) begin
            if ((occ_reg > OCC_W'(k + 1)) && (cell_entry[k+1] < cell_entry[k])) begin
                sorted_ok = 1'b0;
            end
        end
    end

    `SPQ_ASSERT(a_occ_bound, occ_reg <= OCC_W'(DEPTH), "occupancy above depth")
    `SPQ_ASSERT(a_sorted, sorted_ok, "live entries out of order")
    `SPQ_ASSERT_NEXT(a_insert_grows, cmd.insert, occ_reg == $past(occ_reg) + OCC_W'(1), "insert did not grow occupancy")
    `SPQ_ASSERT_NEXT(a_remove_shrinks, cmd.remove, occ_reg == $past(occ_reg) - OCC_W'(1), "remove did not shrink occupancy")
    `SPQ_ASSERT(a_empty_count, (m_valid_reg && m_data_reg[ST_W-1:0] == ST_EMPTY) |-> (m_data_reg[ST_W+DATA_W +: CNT_W] == '0), "empty status with nonzero count")

endmodule

// ----- design/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell (
    input  logic                             aclk,
    input  spq_pkg::cell_cmd_t               cmd,
    input  logic                             live,
    input  logic                             left_ins,
    input  logic signed [spq_pkg::DATA_W-1:0] left_entry,
    input  logic signed [spq_pkg::DATA_W-1:0] right_entry,
    output logic signed [spq_pkg::DATA_W-1:0] entry,
    output logic                             ins_here
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    // An empty cell counts as holding something larger than any value,
    // so the new value lands after all equal or smaller live entries.
    assign ins_here = !live || (cmd.value < entry_reg);
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert) begin
            if (left_ins) begin
                entry_next = left_entry;
            end else if (ins_here) begin
                entry_next = cmd.value;
            end
        end else if (cmd.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
